/* rtl/depthwise_conv2d_fp16_macros.svh */
// Assertion helpers for the RTL; dwc_back.sv includes them.
`ifndef DEPTHWISE_CONV2D_FP16_MACROS_SVH
`define DEPTHWISE_CONV2D_FP16_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DWC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dwc_pkg.sv */
`timescale 1ns / 1ps
package dwc_pkg;

	localparam int DEF_MAX_IN_HEIGHT = 64;
	localparam int DEF_MAX_IN_WIDTH  = 64;
	localparam int DEF_MAX_KERNEL    = 8;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [15:0] HALF_SIX  = 16'h4600;
	localparam logic [15:0] HALF_QNAN = 16'h7E00;
	localparam logic [14:0] HALF_INF  = 15'h7C00;

	typedef enum logic [1:0] {
		OP_PIXEL  = 2'd0,
		OP_WEIGHT = 2'd1,
		OP_BIAS   = 2'd2,
		OP_CONV   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_IN_HEIGHT  = 3'd0,
		CFG_IN_WIDTH   = 3'd1,
		CFG_KERNEL_H   = 3'd2,
		CFG_KERNEL_W   = 3'd3,
		CFG_STRIDE     = 3'd4,
		CFG_PAD        = 3'd5,
		CFG_DILATION   = 3'd6,
		CFG_ACTIVATION = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_RELU  = 2'd1,
		ACT_RELU6 = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_COL,
		ST_READ,
		ST_MAC,
		ST_ACT
	} bk_state_t;

	// One queued command.
	typedef struct packed {
		op_t         op;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] value;
	} q_item_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

	typedef struct packed {
		logic [6:0] in_height;
		logic [6:0] in_width;
		logic [3:0] kernel_height;
		logic [3:0] kernel_width;
		logic [7:0] stride_pair;
		logic [7:0] pad_pair;
		logic [7:0] dilation_pair;
		logic [1:0] activation_mode;
	} cfg_t;

	// Round mag * 2^elsb to half precision, nearest even.
	function automatic logic [15:0] fp16_round(input logic sgn, input logic [23:0] mag,
			input logic signed [8:0] elsb);
		logic signed [9:0] e;
		logic signed [9:0] ee;
		logic signed [9:0] sh;
		logic [4:0]  p;
		logic [47:0] ext;
		logic [23:0] q;
		logic [23:0] rem;
		logic        up;
		logic [16:0] h;
		logic [15:0] r;
		p = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (mag[i]) p = 5'(i);
		end
		e = $signed({5'b0, p}) + 10'(elsb);
		ee = (e < -10'sd14) ? -10'sd14 : e;
		sh = ee - 10'sd10 - 10'(elsb);
		ext = '0;
		if (sh <= 10'sd0) begin
			q = mag << 5'(-sh);
			rem = '0;
		end else begin
			ext = {mag, 24'b0} >> 6'(sh);
			q = ext[47:24];
			rem = ext[23:0];
		end
		up = (rem > 24'h800000) || ((rem == 24'h800000) && q[0]);
		h = {2'b0, 5'(ee + 10'sd14), 10'b0} + 17'(q) + 17'(up);
		if (mag == '0) begin
			r = {sgn, 15'b0};
		end else if (e > 10'sd15 || h >= 17'(HALF_INF)) begin
			r = {sgn, HALF_INF};
		end else begin
			r = {sgn, h[14:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/dwc_if.sv */
`timescale 1ns / 1ps
// Command channel.
interface dwc_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [5:0]  row;
	logic [5:0]  col;
	logic [15:0] value;
	modport source (output valid, command, row, col, value, input ready);
	modport sink (input valid, command, row, col, value, output ready);
endinterface

// Result channel.
interface dwc_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_value;
	modport source (output valid, out_value, input ready);
	modport sink (input valid, out_value, output ready);
endinterface

// Register write channel.
interface dwc_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/dwc_front.sv */
`timescale 1ns / 1ps
module dwc_front import dwc_pkg::*; #(
	parameter int MAX_IN_HEIGHT = DEF_MAX_IN_HEIGHT,
	parameter int MAX_IN_WIDTH  = DEF_MAX_IN_WIDTH,
	parameter int MAX_KERNEL    = DEF_MAX_KERNEL
) (
	input  logic      clk,
	input  logic      arst_n,
	dwc_cmd_if.sink   cmd,
	output q_head_t   head,
	input  logic      pop
);

	q_item_t    fifo_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	q_item_t    item;
	logic       drop;
	logic       push;

	// Decode the beat and drop writes that land outside the stores.
	always_comb begin
		item.op = op_t'(cmd.command);
		item.row = cmd.row;
		item.col = cmd.col;
		item.value = cmd.value;
		unique case (item.op)
			OP_PIXEL:  drop = (int'(cmd.row) >= MAX_IN_HEIGHT) || (int'(cmd.col) >= MAX_IN_WIDTH);
			OP_WEIGHT: drop = (int'(cmd.row) >= MAX_KERNEL) || (int'(cmd.col) >= MAX_KERNEL);
			default:   drop = 1'b0;
		endcase
	end

	assign cmd.ready = (count_q != 2'(QUEUE_DEPTH));
	assign push = cmd.valid && cmd.ready && !drop;
	assign head.valid = (count_q != 2'd0);
	assign head.item = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* rtl/dwc_fp16_mac.sv */
`timescale 1ns / 1ps
module dwc_fp16_mac import dwc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] a,
	input  logic [15:0] b,
	input  logic [15:0] c,
	output logic        done,
	output logic [15:0] result
);

	logic v_s1, v_s2, v_s3, v_s4;

	logic              p_sgn_s1;
	logic [21:0]       p_mag_s1;
	logic signed [8:0] p_elsb_s1;
	logic              p_spec_s1;
	logic [15:0]       p_spec_val_s1;
	logic [15:0]       c_s1;
	logic [15:0]       prod_s2;
	logic [15:0]       c_s2;
	logic              s_sgn_s3;
	logic [14:0]       s_mag_s3;
	logic signed [8:0] s_elsb_s3;
	logic              s_spec_s3;
	logic [15:0]       s_spec_val_s3;
	logic [15:0]       res_s4;

	// Multiply operand decode.
	logic [4:0]  ea, eb, ea1, eb1;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, p_sgn, p_spec;
	logic [15:0] p_spec_val;
	logic [10:0] ma, mb;

	always_comb begin
		ea = a[14:10];
		eb = b[14:10];
		ea1 = (ea == 5'd0) ? 5'd1 : ea;
		eb1 = (eb == 5'd0) ? 5'd1 : eb;
		ma = {ea != 5'd0, a[9:0]};
		mb = {eb != 5'd0, b[9:0]};
		nan_a = (ea == 5'd31) && (a[9:0] != 10'd0);
		nan_b = (eb == 5'd31) && (b[9:0] != 10'd0);
		inf_a = (a[14:0] == HALF_INF);
		inf_b = (b[14:0] == HALF_INF);
		zero_a = (a[14:0] == 15'd0);
		zero_b = (b[14:0] == 15'd0);
		p_sgn = a[15] ^ b[15];
		p_spec = 1'b1;
		if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
			p_spec_val = HALF_QNAN;
		end else if (inf_a || inf_b) begin
			p_spec_val = {p_sgn, HALF_INF};
		end else begin
			p_spec = 1'b0;
			p_spec_val = '0;
		end
	end

	// Add operand decode: A is the operand of larger magnitude.
	logic [15:0] op_a, op_b;
	logic [4:0]  eA1, eB1, d;
	logic [10:0] mA, mB;
	logic [13:0] full_b, sh_b, mbx;
	logic        stk, nan_x, nan_y, inf_x, inf_y, s_spec, s_sgn;
	logic [15:0] s_spec_val;
	logic [14:0] sum;

	always_comb begin
		if (prod_s2[14:0] >= c_s2[14:0]) begin
			op_a = prod_s2;
			op_b = c_s2;
		end else begin
			op_a = c_s2;
			op_b = prod_s2;
		end
		eA1 = (op_a[14:10] == 5'd0) ? 5'd1 : op_a[14:10];
		eB1 = (op_b[14:10] == 5'd0) ? 5'd1 : op_b[14:10];
		mA = {op_a[14:10] != 5'd0, op_a[9:0]};
		mB = {op_b[14:10] != 5'd0, op_b[9:0]};
		d = eA1 - eB1;
		full_b = {mB, 3'b0};
		if (d >= 5'd14) begin
			sh_b = '0;
			stk = (mB != 11'd0);
		end else begin
			sh_b = full_b >> d;
			stk = ((full_b & ~(14'h3FFF << d)) != 14'd0);
		end
		mbx = {sh_b[13:1], sh_b[0] | stk};
		if (op_a[15] == op_b[15]) begin
			sum = {1'b0, mA, 3'b0} + {1'b0, mbx};
		end else begin
			sum = {1'b0, mA, 3'b0} - {1'b0, mbx};
		end
		s_sgn = (sum == 15'd0) ? 1'b0 : op_a[15];
		nan_x = (prod_s2[14:10] == 5'd31) && (prod_s2[9:0] != 10'd0);
		nan_y = (c_s2[14:10] == 5'd31) && (c_s2[9:0] != 10'd0);
		inf_x = (prod_s2[14:0] == HALF_INF);
		inf_y = (c_s2[14:0] == HALF_INF);
		s_spec = 1'b1;
		if (nan_x || nan_y || (inf_x && inf_y && (prod_s2[15] != c_s2[15]))) begin
			s_spec_val = HALF_QNAN;
		end else if (inf_x) begin
			s_spec_val = prod_s2;
		end else if (inf_y) begin
			s_spec_val = c_s2;
		end else if ((prod_s2[14:0] == 15'd0) && (c_s2[14:0] == 15'd0)) begin
			s_spec_val = {prod_s2[15] & c_s2[15], 15'd0};
		end else begin
			s_spec = 1'b0;
			s_spec_val = '0;
		end
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Multiply, round product, align and add, round sum.
	always_ff @(posedge clk) begin
		p_sgn_s1 <= p_sgn;
		p_mag_s1 <= ma * mb;
		p_elsb_s1 <= $signed({4'b0, ea1}) + $signed({4'b0, eb1}) - 9'sd50;
		p_spec_s1 <= p_spec;
		p_spec_val_s1 <= p_spec_val;
		c_s1 <= c;
		prod_s2 <= p_spec_s1 ? p_spec_val_s1 : fp16_round(p_sgn_s1, {2'b0, p_mag_s1}, p_elsb_s1);
		c_s2 <= c_s1;
		s_sgn_s3 <= s_sgn;
		s_mag_s3 <= sum;
		s_elsb_s3 <= $signed({4'b0, eA1}) - 9'sd28;
		s_spec_s3 <= s_spec;
		s_spec_val_s3 <= s_spec_val;
		res_s4 <= s_spec_s3 ? s_spec_val_s3 : fp16_round(s_sgn_s3, {9'b0, s_mag_s3}, s_elsb_s3);
	end

	assign done = v_s4;
	assign result = res_s4;

endmodule

/* rtl/dwc_back.sv */
`timescale 1ns / 1ps
`include "depthwise_conv2d_fp16_macros.svh"
module dwc_back import dwc_pkg::*; #(
	parameter int MAX_IN_HEIGHT = DEF_MAX_IN_HEIGHT,
	parameter int MAX_IN_WIDTH  = DEF_MAX_IN_WIDTH,
	parameter int MAX_KERNEL    = DEF_MAX_KERNEL
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  q_head_t   head,
	output logic      pop,
	dwc_res_if.source res
);

	localparam int IMG_DEPTH = MAX_IN_HEIGHT * MAX_IN_WIDTH;
	localparam int WT_DEPTH  = MAX_KERNEL * MAX_KERNEL;
	localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int WAW = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
	localparam int KW  = $clog2(MAX_KERNEL + 1);

	logic [15:0] img_mem [IMG_DEPTH];
	logic [15:0] wt_mem [WT_DEPTH];

	bk_state_t state_q, state_d;
	logic signed [12:0] y_q, x_q, ox0_q, oy0, ox0;
	logic [KW-1:0] ky_q, kx_q;
	logic [15:0] acc_q, bias_q, pix_q, wt_q, out_q, act_val;
	logic        out_valid_q;
	logic        row_done, col_done, y_in, x_in, out_free;
	logic        rd_en, mac_start, out_load, mac_done;
	logic [15:0] mac_res;
	logic [3:0]  sy, sx, py, px, dy, dx;
	logic [IAW-1:0] img_waddr, img_raddr;
	logic [WAW-1:0] wt_waddr, wt_raddr;

	assign sy = cfg.stride_pair[7:4];
	assign sx = cfg.stride_pair[3:0];
	assign py = cfg.pad_pair[7:4];
	assign px = cfg.pad_pair[3:0];
	assign dy = cfg.dilation_pair[7:4];
	assign dx = cfg.dilation_pair[3:0];

	// Window origin of the requested output point.
	assign oy0 = $signed(13'({7'b0, head.item.row} * {9'b0, sy}) - {9'b0, py});
	assign ox0 = $signed(13'({7'b0, head.item.col} * {9'b0, sx}) - {9'b0, px});

	// Loop bounds and padding checks.
	assign row_done = (int'(ky_q) >= int'(cfg.kernel_height)) || (int'(ky_q) >= MAX_KERNEL);
	assign col_done = (int'(kx_q) >= int'(cfg.kernel_width)) || (int'(kx_q) >= MAX_KERNEL);
	assign y_in = (y_q >= 13'sd0) && (int'(y_q) < int'(cfg.in_height)) &&
		(int'(y_q) < MAX_IN_HEIGHT);
	assign x_in = (x_q >= 13'sd0) && (int'(x_q) < int'(cfg.in_width)) &&
		(int'(x_q) < MAX_IN_WIDTH);
	assign out_free = !out_valid_q || res.ready;

	assign img_waddr = IAW'(int'(head.item.row) * MAX_IN_WIDTH + int'(head.item.col));
	assign wt_waddr = WAW'(int'(head.item.row) * MAX_KERNEL + int'(head.item.col));
	assign img_raddr = IAW'(int'(y_q) * MAX_IN_WIDTH + int'(x_q));
	assign wt_raddr = WAW'(int'(ky_q) * MAX_KERNEL + int'(kx_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (head.valid && head.item.op == OP_CONV) state_d = ST_ROW;
			ST_ROW: begin
				if (row_done) state_d = ST_ACT;
				else if (y_in) state_d = ST_COL;
			end
			ST_COL: begin
				if (col_done) state_d = ST_ROW;
				else if (x_in) state_d = ST_READ;
			end
			ST_READ: state_d = ST_MAC;
			ST_MAC: if (mac_done) state_d = ST_COL;
			ST_ACT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		pop = (state_q == ST_IDLE) && head.valid;
		rd_en = (state_q == ST_COL) && !col_done && x_in;
		mac_start = (state_q == ST_READ);
		out_load = (state_q == ST_ACT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Stores: written from the queue, read one tap at a time.
	always_ff @(posedge clk) begin
		if (pop && head.item.op == OP_PIXEL) img_mem[img_waddr] <= head.item.value;
		if (pop && head.item.op == OP_WEIGHT) wt_mem[wt_waddr] <= head.item.value;
		if (rd_en) begin
			pix_q <= img_mem[img_raddr];
			wt_q <= wt_mem[wt_raddr];
		end
	end

	// Tap walk and accumulator.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop && head.item.op == OP_CONV) begin
					y_q <= oy0;
					ox0_q <= ox0;
					ky_q <= '0;
					acc_q <= bias_q;
				end
			end
			ST_ROW: begin
				if (!row_done && y_in) begin
					kx_q <= '0;
					x_q <= ox0_q;
				end else if (!row_done) begin
					ky_q <= ky_q + 1'b1;
					y_q <= y_q + $signed({9'b0, dy});
				end
			end
			ST_COL: begin
				if (col_done) begin
					ky_q <= ky_q + 1'b1;
					y_q <= y_q + $signed({9'b0, dy});
				end else if (!x_in) begin
					kx_q <= kx_q + 1'b1;
					x_q <= x_q + $signed({9'b0, dx});
				end
			end
			ST_MAC: begin
				if (mac_done) begin
					acc_q <= mac_res;
					kx_q <= kx_q + 1'b1;
					x_q <= x_q + $signed({9'b0, dx});
				end
			end
			default: ;
		endcase
		if (out_load) out_q <= act_val;
	end

	// Bias register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.item.op == OP_BIAS) bias_q <= head.item.value;
			if (out_load) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	// NaN canonicalization and activation.
	always_comb begin
		act_val = (acc_q[14:0] > HALF_INF) ? HALF_QNAN : acc_q;
		if (cfg.activation_mode == ACT_RELU || cfg.activation_mode == ACT_RELU6) begin
			if (act_val[15] || act_val > {1'b0, HALF_INF}) act_val = '0;
			if (cfg.activation_mode == ACT_RELU6 && act_val > HALF_SIX) act_val = HALF_SIX;
		end
	end

	dwc_fp16_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.a      (pix_q),
		.b      (wt_q),
		.c      (acc_q),
		.done   (mac_done),
		.result (mac_res)
	);

	assign res.valid = out_valid_q;
	assign res.out_value = out_q;

	`DWC_ASSERT_IMP(a_start_in_read, clk, arst_n, mac_start, state_q == ST_READ, "MAC start outside read step")
	`DWC_ASSERT_NEXT(a_read_to_mac, clk, arst_n, state_q == ST_READ, state_q == ST_MAC, "read step not followed by MAC wait")
	`DWC_ASSERT_IMP(a_done_in_mac, clk, arst_n, mac_done, state_q == ST_MAC, "MAC result arrived outside MAC wait")

endmodule

/* rtl/depthwise_conv2d_fp16.sv */
`timescale 1ns / 1ps
// Write beats (pixel, weight, bias) drain from the command queue at one per cycle while
// no compute beat is in progress. A compute beat walks the kernel rows, and within each
// in-bounds row its taps; out-of-bounds taps and rows are skipped, and the activation
// step follows the last row. Each in-bounds tap is stepped, read from the stores and
// passed through the multiply-add unit.
// Asynchronous active-low reset restores register defaults, zero bias, empty queue;
// pixel and weight stores are not cleared.
module depthwise_conv2d_fp16 import dwc_pkg::*; #(
	parameter int MAX_IN_HEIGHT = DEF_MAX_IN_HEIGHT,
	parameter int MAX_IN_WIDTH  = DEF_MAX_IN_WIDTH,
	parameter int MAX_KERNEL    = DEF_MAX_KERNEL
) (
	input  logic      clk,
	input  logic      arst_n,
	dwc_cmd_if.sink   cmd,
	dwc_res_if.source res,
	dwc_cfg_if.sink   cfg
);

	cfg_t    cfg_q;
	q_head_t head;
	logic    pop;

	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_height <= 7'd64;
			cfg_q.in_width <= 7'd64;
			cfg_q.kernel_height <= 4'd3;
			cfg_q.kernel_width <= 4'd3;
			cfg_q.stride_pair <= 8'd17;
			cfg_q.pad_pair <= 8'd0;
			cfg_q.dilation_pair <= 8'd17;
			cfg_q.activation_mode <= ACT_NONE;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_IN_HEIGHT:  cfg_q.in_height <= cfg.data[6:0];
				CFG_IN_WIDTH:   cfg_q.in_width <= cfg.data[6:0];
				CFG_KERNEL_H:   cfg_q.kernel_height <= cfg.data[3:0];
				CFG_KERNEL_W:   cfg_q.kernel_width <= cfg.data[3:0];
				CFG_STRIDE:     cfg_q.stride_pair <= cfg.data;
				CFG_PAD:        cfg_q.pad_pair <= cfg.data;
				CFG_DILATION:   cfg_q.dilation_pair <= cfg.data;
				CFG_ACTIVATION: cfg_q.activation_mode <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	dwc_front #(
		.MAX_IN_HEIGHT (MAX_IN_HEIGHT),
		.MAX_IN_WIDTH  (MAX_IN_WIDTH),
		.MAX_KERNEL    (MAX_KERNEL)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head),
		.pop    (pop)
	);

	dwc_back #(
		.MAX_IN_HEIGHT (MAX_IN_HEIGHT),
		.MAX_IN_WIDTH  (MAX_IN_WIDTH),
		.MAX_KERNEL    (MAX_KERNEL)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule

/* tb/sv/dwc_conv_checker.sv */
`timescale 1ns / 1ps
// Watches the three channels, keeps its own copy of the block's stores and
// registers, predicts each convolution output and compares the result beats.
module dwc_conv_checker import dwc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	dwc_cmd_if    cmd,
	dwc_res_if    res,
	dwc_cfg_if    cfg,
	output int    errors,
	output int    pending
);

	logic [15:0] pixels [0:4095];
	logic [15:0] weights [0:63];
	logic [15:0] bias;
	cfg_t        regs;
	logic [15:0] conv_expected [$];

	// Exact widening of a half pattern to a real.
	function automatic real half_to_real(logic [15:0] h);
		logic [63:0] bits;
		int          ex;
		logic [10:0] m;
		ex = h[14:10];
		m = {1'b0, h[9:0]};
		if (ex == 31) begin
			bits = {h[15], 11'h7FF, (m != 0), 51'b0};
		end else if (ex == 0 && m == 0) begin
			bits = {h[15], 63'b0};
		end else begin
			if (ex == 0) begin
				ex = -14;
				while (!m[10]) begin
					m = m << 1;
					ex--;
				end
			end else begin
				ex = ex - 15;
			end
			bits = {h[15], 11'(ex + 1023), m[9:0], 42'b0};
		end
		return $bitstoreal(bits);
	endfunction

	// Round a real to half precision, nearest even.
	function automatic logic [15:0] real_to_half(real x);
		logic [63:0]     bits;
		longint unsigned sig, q, rem, halfway;
		int              e, en, shift;
		logic [31:0]     h;
		bits = $realtobits(x);
		sig = {12'b0, bits[51:0]};
		if (bits[62:52] == 11'h7FF)
			return (sig != 0) ? HALF_QNAN : {bits[63], HALF_INF};
		if (bits[62:52] == 11'h000)
			return {bits[63], 15'b0};
		e = int'(bits[62:52]) - 1023;
		if (e > 15)
			return {bits[63], HALF_INF};
		en = (e < -14) ? -14 : e;
		shift = 42 + (en - e);
		if (shift > 60)
			return {bits[63], 15'b0};
		sig = sig | (64'd1 << 52);
		q = sig >> shift;
		rem = sig & ((64'd1 << shift) - 1);
		halfway = 64'd1 << (shift - 1);
		if (rem > halfway || (rem == halfway && q[0]))
			q++;
		h = 32'((en + 14) << 10) + 32'(q);
		if (h >= 32'h7C00)
			return {bits[63], HALF_INF};
		return {bits[63], h[14:0]};
	endfunction

	// Convolution output at one output coordinate, with activation.
	function automatic logic [15:0] conv_point(logic [5:0] orow, logic [5:0] ocol);
		int          ih, iw, kh, kw, y0, x0, y, x;
		logic [15:0] acc, prod;
		ih = (regs.in_height > 64) ? 64 : regs.in_height;
		iw = (regs.in_width > 64) ? 64 : regs.in_width;
		kh = (regs.kernel_height > 8) ? 8 : regs.kernel_height;
		kw = (regs.kernel_width > 8) ? 8 : regs.kernel_width;
		y0 = int'(orow) * regs.stride_pair[7:4] - regs.pad_pair[7:4];
		x0 = int'(ocol) * regs.stride_pair[3:0] - regs.pad_pair[3:0];
		acc = bias;
		for (int ky = 0; ky < kh; ky++) begin
			y = y0 + ky * regs.dilation_pair[7:4];
			if (y < 0 || y >= ih)
				continue;
			for (int kx = 0; kx < kw; kx++) begin
				x = x0 + kx * regs.dilation_pair[3:0];
				if (x < 0 || x >= iw)
					continue;
				prod = real_to_half(half_to_real(pixels[y * 64 + x]) *
					half_to_real(weights[ky * 8 + kx]));
				acc = real_to_half(half_to_real(acc) + half_to_real(prod));
			end
		end
		if (acc[14:0] > HALF_INF)
			acc = HALF_QNAN;
		if (regs.activation_mode == ACT_RELU || regs.activation_mode == ACT_RELU6) begin
			if (acc[15] || acc > {1'b0, HALF_INF})
				acc = '0;
			if (regs.activation_mode == ACT_RELU6 && acc > HALF_SIX)
				acc = HALF_SIX;
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			regs <= '{in_height: 7'd64, in_width: 7'd64, kernel_height: 4'd3,
				kernel_width: 4'd3, stride_pair: 8'h11, pad_pair: 8'h00,
				dilation_pair: 8'h11, activation_mode: 2'd0};
			bias <= '0;
			conv_expected.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			// Result beats are compared first; a result never stems from the
			// command beat of the same edge.
			if (res.valid && res.ready) begin
				if (conv_expected.size() == 0) begin
					if (errors < 10)
						$display("[%0t] unexpected result beat 0x%04h", $realtime,
							res.out_value);
					errors <= errors + 1;
				end else begin
					want = conv_expected.pop_front();
					if (res.out_value !== want) begin
						if (errors < 10)
							$display("[%0t] out_value mismatch: expected 0x%04h got 0x%04h",
								$realtime, want, res.out_value);
						errors <= errors + 1;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					CFG_IN_HEIGHT:  regs.in_height <= cfg.data[6:0];
					CFG_IN_WIDTH:   regs.in_width <= cfg.data[6:0];
					CFG_KERNEL_H:   regs.kernel_height <= cfg.data[3:0];
					CFG_KERNEL_W:   regs.kernel_width <= cfg.data[3:0];
					CFG_STRIDE:     regs.stride_pair <= cfg.data;
					CFG_PAD:        regs.pad_pair <= cfg.data;
					CFG_DILATION:   regs.dilation_pair <= cfg.data;
					CFG_ACTIVATION: regs.activation_mode <= cfg.data[1:0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready) begin
				case (op_t'(cmd.command))
					OP_PIXEL: pixels[{cmd.row, cmd.col}] = cmd.value;
					OP_WEIGHT: begin
						if (cmd.row < 8 && cmd.col < 8)
							weights[cmd.row * 8 + cmd.col] = cmd.value;
					end
					OP_BIAS: bias <= cmd.value;
					OP_CONV: conv_expected.push_back(conv_point(cmd.row, cmd.col));
					default: ;
				endcase
			end
			pending <= conv_expected.size();
		end
	end

endmodule

/* tb/sv/tb_depthwise_conv2d_fp16.sv */
`timescale 1ns / 1ps
module tb_depthwise_conv2d_fp16;
	import dwc_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending;
	bit   no_idle = 0;
	bit   hold_req = 0;
	int   quiet_cycles = 0;

	// Shadow of the sizes and of which store entries have been written, so
	// that no compute reads an entry that was never written.
	cfg_t shadow;
	bit   pix_ok [0:4095];
	bit   wt_ok [0:63];

	dwc_cmd_if cmd_if ();
	dwc_res_if res_if ();
	dwc_cfg_if cfg_if ();

	depthwise_conv2d_fp16 dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_if.sink), .res(res_if.source), .cfg(cfg_if.sink)
	);

	dwc_conv_checker conv_check (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_if), .res(res_if), .cfg(cfg_if),
		.errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random back-pressure, with a long hold-off on request.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			res_if.ready <= no_idle || ($urandom_range(99) >= 28);
		end
	end

	// Half-precision operands, mostly of moderate magnitude.
	function automatic logic [15:0] rand_half();
		logic [15:0] specials [9] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
			16'h7BFF, 16'h0001, 16'h0400, 16'h4600};
		case ($urandom_range(9))
			6: return specials[$urandom_range(8)];
			7, 8, 9: return 16'($urandom);
			default: return {1'($urandom), 5'($urandom_range(17, 13)), 10'($urandom)};
		endcase
	endfunction

	// One command beat; called and returning at a falling edge.
	task automatic send(op_t op, logic [5:0] r, logic [5:0] c, logic [15:0] v);
		while (!no_idle && $urandom_range(99) < 28) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.command <= op;
		cmd_if.row <= r;
		cmd_if.col <= c;
		cmd_if.value <= v;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		@(negedge clk);
		if (op == OP_PIXEL)
			pix_ok[{r, c}] = 1;
		if (op == OP_WEIGHT && r < 8 && c < 8)
			wt_ok[r * 8 + c] = 1;
	endtask

	// Compute at one coordinate, first writing any tap it would read unwritten.
	task automatic conv_at(logic [5:0] r, logic [5:0] c);
		int ih, iw, kh, kw, y0, x0, y, x;
		ih = (shadow.in_height > 64) ? 64 : shadow.in_height;
		iw = (shadow.in_width > 64) ? 64 : shadow.in_width;
		kh = (shadow.kernel_height > 8) ? 8 : shadow.kernel_height;
		kw = (shadow.kernel_width > 8) ? 8 : shadow.kernel_width;
		y0 = int'(r) * shadow.stride_pair[7:4] - shadow.pad_pair[7:4];
		x0 = int'(c) * shadow.stride_pair[3:0] - shadow.pad_pair[3:0];
		for (int ky = 0; ky < kh; ky++) begin
			y = y0 + ky * shadow.dilation_pair[7:4];
			for (int kx = 0; kx < kw; kx++) begin
				x = x0 + kx * shadow.dilation_pair[3:0];
				if (y < 0 || y >= ih || x < 0 || x >= iw)
					continue;
				if (!wt_ok[ky * 8 + kx])
					send(OP_WEIGHT, 6'(ky), 6'(kx), rand_half());
				if (!pix_ok[y * 64 + x])
					send(OP_PIXEL, 6'(y), 6'(x), rand_half());
			end
		end
		send(OP_CONV, r, c, 16'($urandom));
	endtask

	// One register write; returns at a falling edge with valid still high.
	task automatic reg_write(cfg_idx_t idx, logic [7:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		case (idx)
			CFG_IN_HEIGHT:  shadow.in_height = data[6:0];
			CFG_IN_WIDTH:   shadow.in_width = data[6:0];
			CFG_KERNEL_H:   shadow.kernel_height = data[3:0];
			CFG_KERNEL_W:   shadow.kernel_width = data[3:0];
			CFG_STRIDE:     shadow.stride_pair = data;
			CFG_PAD:        shadow.pad_pair = data;
			CFG_DILATION:   shadow.dilation_pair = data;
			CFG_ACTIVATION: shadow.activation_mode = data[1:0];
			default: ;
		endcase
	endtask

	// Waits until every result is in and the write queue has drained.
	task automatic drain();
		cmd_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic load_regs(logic [7:0] v [8]);
		drain();
		for (int i = 0; i < 8; i++)
			reg_write(cfg_idx_t'(i), v[i]);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		logic [7:0] setting [8];
		int         n_items;
		int         pick;
		cmd_if.valid = 1'b0;
		cmd_if.command = OP_PIXEL;
		cmd_if.row = '0;
		cmd_if.col = '0;
		cmd_if.value = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_IN_HEIGHT;
		cfg_if.data = '0;
		shadow = '{in_height: 7'd64, in_width: 7'd64, kernel_height: 4'd3,
			kernel_width: 4'd3, stride_pair: 8'h11, pad_pair: 8'h00,
			dilation_pair: 8'h11, activation_mode: 2'd0};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats under the reset configuration: overflow, subnormals,
		// NaN and infinities, out-of-range weight writes, image corners.
		send(OP_WEIGHT, 6'd0, 6'd0, 16'h7BFF);
		send(OP_WEIGHT, 6'd0, 6'd1, 16'h0001);
		send(OP_WEIGHT, 6'd1, 6'd1, 16'h8000);
		send(OP_WEIGHT, 6'd8, 6'd0, 16'h1234);
		send(OP_WEIGHT, 6'd63, 6'd63, 16'hFFFF);
		send(OP_PIXEL, 6'd0, 6'd0, 16'h7BFF);
		send(OP_PIXEL, 6'd0, 6'd1, 16'h0001);
		send(OP_PIXEL, 6'd63, 6'd63, 16'hFFFF);
		send(OP_PIXEL, 6'd1, 6'd1, 16'h0000);
		conv_at(6'd0, 6'd0);
		send(OP_BIAS, 6'd0, 6'd0, 16'h3C00);
		conv_at(6'd63, 6'd63);
		conv_at(6'd31, 6'd17);
		send(OP_BIAS, 6'd63, 6'd63, 16'h7C00);
		conv_at(6'd1, 6'd1);
		send(OP_BIAS, 6'd0, 6'd0, 16'hFC00);
		conv_at(6'd0, 6'd0);
		send(OP_BIAS, 6'd0, 6'd0, 16'h8000);
		conv_at(6'd62, 6'd0);

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: setting = '{8, 8, 3, 3, 8'h11, 8'h11, 8'h11, ACT_RELU};
				1: setting = '{64, 64, 8, 8, 8'h11, 8'h00, 8'h11, ACT_RELU6};
				2: setting = '{1, 1, 1, 1, 8'h11, 8'h00, 8'h11, ACT_NONE};
				3: setting = '{127, 127, 15, 15, 8'hFF, 8'hFF, 8'hFF, 3};
				4: setting = '{0, 0, 0, 0, 8'h00, 8'h00, 8'h00, ACT_RELU};
				5: setting = '{16, 12, 5, 4, 8'h21, 8'h32, 8'h23, ACT_RELU6};
				default: setting = '{8'($urandom_range(20, 1)), 8'($urandom_range(20, 1)),
					8'($urandom_range(8, 1)), 8'($urandom_range(8, 1)), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom_range(3))};
			endcase
			load_regs(setting);
			no_idle = (ph == 2);
			// The large kernel on the full image writes many pixels per compute.
			n_items = (ph == 1) ? 10 : ((ph == 3) ? 60 : 100);
			for (int i = 0; i < n_items; i++) begin
				// Fill the queue against a stalled result side.
				if (ph == 5 && i == 20) begin
					hold_req = 1;
					for (int k = 0; k < 8; k++)
						conv_at(6'($urandom_range(15)), 6'($urandom_range(11)));
				end
				// Stop sending until every expected result has arrived.
				if (i == n_items / 2)
					drain();
				pick = $urandom_range(99);
				if (pick < 12)
					send(OP_BIAS, 6'($urandom), 6'($urandom), rand_half());
				else if (pick < 35)
					send(OP_PIXEL, 6'($urandom), 6'($urandom), rand_half());
				else if (pick < 50)
					send(OP_WEIGHT, 6'($urandom_range(11)), 6'($urandom_range(11)),
						rand_half());
				else if (ph == 1 || ph == 5 || ph >= 6)
					conv_at(6'($urandom_range(shadow.in_height)),
						6'($urandom_range(shadow.in_width)));
				else
					conv_at(6'($urandom), 6'($urandom));
			end
			no_idle = 0;
		end

		drain();
		repeat (500) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/dwc_pkg.sv
rtl/dwc_if.sv
rtl/dwc_front.sv
rtl/dwc_fp16_mac.sv
rtl/dwc_back.sv
rtl/depthwise_conv2d_fp16.sv
tb/sv/dwc_conv_checker.sv
tb/sv/tb_depthwise_conv2d_fp16.sv
